/* rtl/fnvx_pkg.sv */
`timescale 1ns / 1ps

package fnvx_pkg;

   localparam int DIGEST_BYTES = 32;
   localparam int CNT_W        = $clog2(DIGEST_BYTES);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

   typedef enum logic [1:0] {
      OP_ABSORB        = 2'd0,
      OP_ABSORB_FINISH = 2'd1,
      OP_FINISH        = 2'd2,
      OP_RESERVED      = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [4:0]  byte_index;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic        absorb;
      logic        finish;
      logic [7:0]  data;
   } cmd_type;

   // x * 0x100000001b3 mod 2^64, prime = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1
   function automatic logic [63:0] mul_prime(input logic [63:0] x);
      mul_prime = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

/* rtl/fnvx_front.sv */
`timescale 1ns / 1ps

module fnvx_front import fnvx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_word_type req_word,
   output logic         req_full,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  logic         cmd_pop
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             cmd_in;
   logic                keep;
   logic                push_fire;
   logic                write;
   logic                pop_fire;

   always_comb begin
      cmd_in.data = req_word.data;
      unique case (req_word.op)
         OP_ABSORB: begin
            cmd_in.absorb = 1'b1;
            cmd_in.finish = 1'b0;
            keep          = 1'b1;
         end
         OP_ABSORB_FINISH: begin
            cmd_in.absorb = 1'b1;
            cmd_in.finish = 1'b1;
            keep          = 1'b1;
         end
         OP_FINISH: begin
            cmd_in.absorb = 1'b0;
            cmd_in.finish = 1'b1;
            keep          = 1'b1;
         end
         default: begin
            cmd_in.absorb = 1'b0;
            cmd_in.finish = 1'b0;
            keep          = 1'b0;
         end
      endcase
   end

   assign req_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = mem_ff[rd_ptr_ff];
   assign push_fire = req_push && !req_full;
   assign write     = push_fire && keep;
   assign pop_fire  = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = write    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (write && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (!write && pop_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (write) begin
         mem_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count over depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (write && !pop_fire) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a write");

   a_reserved_drop: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !keep && !pop_fire) |=> $stable(count_ff))
      else $error("reserved op entered queue");

endmodule

/* rtl/fnvx_back.sv */
`timescale 1ns / 1ps

module fnvx_back import fnvx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_pop,
   output logic         rsp_empty,
   output rsp_word_type rsp_word,
   input  logic         rsp_pop
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [63:0]        hash_ff, hash_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               out_valid_ff, out_valid_in;
   rsp_word_type       out_ff, out_in;
   logic               slot_free;
   logic               emit_fire;
   logic               emit_last;
   logic [7:0]         cur_byte;
   logic [63:0]        absorbed;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign emit_last = (cnt_ff == CNT_W'(DIGEST_BYTES - 1));
   assign cur_byte  = hash_ff[8*cnt_ff[2:0] +: 8];
   assign absorbed  = mul_prime(hash_ff ^ {56'd0, cmd.data});

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      cmd_pop      = 1'b0;
      emit_fire    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.absorb) begin
                  hash_in = absorbed;
               end
               if (cmd.finish) begin
                  cnt_in   = '0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               emit_fire           = 1'b1;
               out_valid_in        = 1'b1;
               out_in.out_byte     = cur_byte;
               out_in.byte_index   = 5'(cnt_ff);
               out_in.last         = emit_last;
               if (emit_last) begin
                  hash_in  = FNV_BASIS;
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  hash_in = mul_prime(hash_ff) + {56'd0, cur_byte};
                  cnt_in  = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_ff;

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= FNV_BASIS;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> state_ff == ST_IDLE)
      else $error("command taken during digest output");

   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && emit_last) |=> state_ff == ST_IDLE && hash_ff == FNV_BASIS)
      else $error("state not restored after last byte");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && !emit_last) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("digest counter skipped");

endmodule

/* rtl/fnv1a64_hash_extend_256.sv */
`timescale 1ns / 1ps
// First digest word: after the queue, back-end state register and output register.
// Throughput: one absorb word per cycle; a finish emits 32 words, one per cycle
// while the output slot is free. The back end holds off the queue while it emits.
// Reset is synchronous, active high: queue and output empty, state at offset basis.

module fnv1a64_hash_extend_256 import fnvx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_word_type req_word,
   output logic         req_full,
   output logic         rsp_empty,
   output rsp_word_type rsp_word,
   input  logic         rsp_pop
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   fnvx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_word  (req_word),
      .req_full  (req_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   fnvx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_word  (rsp_word),
      .rsp_pop   (rsp_pop)
   );

endmodule
